>>> src/utf8u16_pkg.sv
// ============================================================================
// UTF-8 to UTF-16 transcoder package
// Shared constants, status codes and result types of the transcoder.
// ============================================================================
`timescale 1ns / 1ps

package utf8u16_pkg;

    // Saturation limit of the per-string unit count.
    localparam longint unsigned MAX_UNITS = 64'd65535;
    localparam logic [15:0] UNIT_CAP =
        (MAX_UNITS < 64'd65535) ? 16'(MAX_UNITS) : 16'hFFFF;

    // Largest number of result words caused by one input byte.
    localparam int RES_MAX = 3;

    // Depth of the result queue; must hold two bytes' worth of results.
    localparam int QUEUE_DEPTH = 8;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // Status codes of a result word.
    localparam logic [1:0] ST_UNIT   = 2'd0;
    localparam logic [1:0] ST_ACCEPT = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;

    // Unicode limits.
    localparam logic [20:0] CP_MAX       = 21'h10FFFF;
    localparam logic [20:0] CP_SURR_LO   = 21'h00D800;
    localparam logic [20:0] CP_SURR_HI   = 21'h00DFFF;
    localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
    localparam logic [15:0] HIGH_SURR    = 16'hD800;
    localparam logic [15:0] LOW_SURR     = 16'hDC00;

    typedef struct packed {
        logic [15:0] code_unit;
        logic [1:0]  status;
        logic [15:0] unit_total;
        logic        last_of_run;
    } result_t;

    typedef result_t [RES_MAX-1:0] result_vec_t;

    // Saturating increment of the unit count.
    function automatic logic [15:0] sat_inc(input logic [15:0] cnt);
        logic [15:0] res;
        res = (cnt < UNIT_CAP) ? 16'(cnt + 16'd1) : cnt;
        return res;
    endfunction

endpackage

>>> src/utf8u16_if.sv
// ============================================================================
// Transcoder channel interfaces
// Valid/ready channels for the UTF-8 byte stream and the UTF-16 result stream.
// ============================================================================
`timescale 1ns / 1ps

interface utf8u16_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_string;

    modport source (output valid, output in_byte, output end_of_string, input ready);
    modport sink   (input valid, input in_byte, input end_of_string, output ready);
endinterface

interface utf8u16_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic [1:0]  status;
    logic [15:0] unit_total;
    logic        last_of_run;

    modport source (output valid, output code_unit, output status,
                    output unit_total, output last_of_run, input ready);
    modport sink   (input valid, input code_unit, input status,
                    input unit_total, input last_of_run, output ready);
endinterface

>>> src/utf8_to_utf16_transcoder.sv
// A byte accepted on utf8 is held in the input register and decoded from there; its words
// are then written to the result queue and offered from it. Throughput: one byte per
// cycle; the output drains one word per cycle while utf16.ready is high, and a byte is taken
// whenever the 8-word queue, past the input register's words, can absorb three more words.
// Reset: rst_n clears the decode state, the input stage and the queue at once.
// ============================================================================
// UTF-8 to UTF-16 transcoder
// Input register, one-byte decode step and a result queue toward the output.
// ============================================================================
`timescale 1ns / 1ps

module utf8_to_utf16_transcoder (
    input  logic                  clk,
    input  logic                  rst_n,
    utf8u16_byte_if.sink          utf8,
    utf8u16_unit_if.source        utf16
);
    import utf8u16_pkg::*;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_eos_reg;

    // Result queue.
    result_t             queue_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_AW:0]   count_reg, count_next;

    result_vec_t results;
    logic [1:0]  result_count;
    logic [1:0]  push_n;
    logic        pop;
    logic        in_accept;
    logic [QUEUE_AW+1:0] fill_after;

    utf8u16_decoder u_decoder (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (in_valid_reg),
        .in_byte      (in_byte_reg),
        .end_of_string(in_eos_reg),
        .results      (results),
        .result_count (result_count)
    );

    // Flow control: a byte is taken only if, besides the input register's words, it finds room next cycle.
    assign push_n     = in_valid_reg ? result_count : 2'd0;
    assign fill_after = {1'b0, count_reg} + {{QUEUE_AW{1'b0}}, push_n};
    assign utf8.ready = (fill_after <= (QUEUE_AW+2)'(QUEUE_DEPTH - RES_MAX));
    assign in_accept  = utf8.valid && utf8.ready;

    // Output side of the queue.
    assign pop               = utf16.valid && utf16.ready;
    assign utf16.valid       = (count_reg != '0);
    assign utf16.code_unit   = queue_reg[rd_ptr_reg].code_unit;
    assign utf16.status      = queue_reg[rd_ptr_reg].status;
    assign utf16.unit_total  = queue_reg[rd_ptr_reg].unit_total;
    assign utf16.last_of_run = queue_reg[rd_ptr_reg].last_of_run;

    // Pointer and fill updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + QUEUE_AW'(push_n);
        rd_ptr_next = pop ? QUEUE_AW'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg + (QUEUE_AW+1)'(push_n) - (QUEUE_AW+1)'(pop);
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            in_valid_reg <= in_accept;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
        end
    end

    // Payload registers: input byte and queue entries.
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            in_byte_reg <= utf8.in_byte;
            in_eos_reg  <= utf8.end_of_string;
        end
        for (int i = 0; i < RES_MAX; i++)
        begin
            if (2'(i) < push_n)
            begin
                queue_reg[QUEUE_AW'(wr_ptr_reg + QUEUE_AW'(i))] <= results[i];
            end
        end
    end

endmodule

>>> src/utf8u16_decoder.sv
// ============================================================================
// UTF-8 decoder step
// Holds the decode state and turns one byte into up to three result words.
// ============================================================================
`timescale 1ns / 1ps

module utf8u16_decoder (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      step,
    input  logic [7:0]                in_byte,
    input  logic                      end_of_string,
    output utf8u16_pkg::result_vec_t  results,
    output logic [1:0]                result_count
);
    import utf8u16_pkg::*;

    logic [20:0] partial_point_reg, partial_point_next;
    logic [1:0]  bytes_pending_reg, bytes_pending_next;
    logic        error_seen_reg, error_seen_next;
    logic [15:0] unit_counter_reg, unit_counter_next;

    logic [20:0] shifted;
    logic [20:0] cp;
    logic [20:0] offset;
    logic        done;
    logic [1:0]  n;

    assign shifted = {partial_point_reg[14:0], in_byte[5:0]};

    // Decode of one byte against the current state.
    always_comb
    begin
        partial_point_next = partial_point_reg;
        bytes_pending_next = bytes_pending_reg;
        error_seen_next    = error_seen_reg;
        unit_counter_next  = unit_counter_reg;
        done               = 1'b0;
        n                  = 2'd0;
        results            = '0;
        cp                 = '0;
        offset             = '0;

        if (!error_seen_reg)
        begin
            if (bytes_pending_reg == 2'd0)
            begin
                // Lead byte: take its payload bits and the sequence length.
                if (in_byte[7] == 1'b0)
                begin
                    partial_point_next = {13'd0, in_byte};
                    done               = 1'b1;
                end
                else if (in_byte inside {[8'hC0:8'hDF]})
                begin
                    partial_point_next = {16'd0, in_byte[4:0]};
                    bytes_pending_next = 2'd1;
                end
                else if (in_byte inside {[8'hE0:8'hEF]})
                begin
                    partial_point_next = {17'd0, in_byte[3:0]};
                    bytes_pending_next = 2'd2;
                end
                else if (in_byte inside {[8'hF0:8'hF7]})
                begin
                    partial_point_next = {18'd0, in_byte[2:0]};
                    bytes_pending_next = 2'd3;
                end
                else
                begin
                    error_seen_next = 1'b1;
                end
            end
            else if (in_byte[7:6] != 2'b10)
            begin
                error_seen_next = 1'b1;
            end
            else
            begin
                partial_point_next = shifted;
                bytes_pending_next = bytes_pending_reg - 2'd1;
                done               = (bytes_pending_reg == 2'd1);
            end

            // A complete code point gives one unit or a surrogate pair.
            if (done)
            begin
                cp     = partial_point_next;
                offset = cp - CP_SUPP_BASE;
                if (cp > CP_MAX || (cp >= CP_SURR_LO && cp <= CP_SURR_HI))
                begin
                    error_seen_next = 1'b1;
                end
                else if (cp >= CP_SUPP_BASE)
                begin
                    results[0].code_unit = HIGH_SURR | {6'd0, offset[19:10]};
                    results[1].code_unit = LOW_SURR | {6'd0, offset[9:0]};
                    n                    = 2'd2;
                    unit_counter_next    = sat_inc(sat_inc(unit_counter_reg));
                end
                else
                begin
                    results[0].code_unit = cp[15:0];
                    n                    = 2'd1;
                    unit_counter_next    = sat_inc(unit_counter_reg);
                end
                partial_point_next = '0;
            end
        end

        // Final byte: report the string status and return to the reset state.
        if (end_of_string)
        begin
            if (bytes_pending_next != 2'd0)
            begin
                error_seen_next = 1'b1;
            end
            if (error_seen_next)
            begin
                results[n].status = ST_REJECT;
            end
            else
            begin
                results[n].status     = ST_ACCEPT;
                results[n].unit_total = unit_counter_next;
            end
            n                  = n + 2'd1;
            partial_point_next = '0;
            bytes_pending_next = '0;
            error_seen_next    = 1'b0;
            unit_counter_next  = '0;
        end

        // Mark the last word caused by this byte.
        if (n != 2'd0)
        begin
            results[n - 2'd1].last_of_run = 1'b1;
        end
    end

    assign result_count = n;

    // Decode state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_point_reg <= '0;
            bytes_pending_reg <= '0;
            error_seen_reg    <= 1'b0;
            unit_counter_reg  <= '0;
        end
        else if (step)
        begin
            partial_point_reg <= partial_point_next;
            bytes_pending_reg <= bytes_pending_next;
            error_seen_reg    <= error_seen_next;
            unit_counter_reg  <= unit_counter_next;
        end
    end

endmodule
